FILE: hdl/cbfc_pkg.sv
package cbfc_pkg;

    localparam int CHUNK_WIDTH  = 16;
    localparam int CHUNK_HEIGHT = 256;
    localparam int CHUNK_DEPTH  = 16;

    localparam int NUM_PLANES = 6;

    // box extents in Q.4
    localparam int X_SPAN = CHUNK_WIDTH * 16;
    localparam int Y_SPAN = CHUNK_HEIGHT * 16;
    localparam int Z_SPAN = CHUNK_DEPTH * 16;

    localparam int COL_W  = 19;
    localparam int CAMXZ_W = 27;
    localparam int CAMY_W = 21;
    localparam int COEF_W = 16;
    localparam int D_SHIFT = 14;

    localparam int XB = COL_W + $clog2(X_SPAN + 1);
    localparam int ZB = COL_W + $clog2(Z_SPAN + 1);
    localparam int XZB = (XB > ZB) ? XB : ZB;
    localparam int CRD_W = ((XZB > CAMXZ_W) ? XZB : CAMXZ_W) + 2;
    localparam int YB = $clog2(Y_SPAN + 1) + 1;
    localparam int Y_W = ((YB > CAMY_W) ? YB : CAMY_W) + 1;

    localparam int PRD_XZ_W = CRD_W + COEF_W;
    localparam int PRD_Y_W  = Y_W + COEF_W;
    localparam int ACC_W0 = ((CRD_W > Y_W) ? CRD_W : Y_W) + COEF_W + 2;
    localparam int ACC_W = (ACC_W0 > COEF_W + D_SHIFT + 1) ? ACC_W0 : COEF_W + D_SHIFT + 1;

    // configuration port
    localparam int DATA_W = 64;
    localparam int ADDR_W = $clog2(NUM_PLANES * 8);
    localparam int IDX_W  = ADDR_W - 3;

    typedef enum logic [IDX_W-1:0] {
        PLANE_LEFT   = 3'd0,
        PLANE_RIGHT  = 3'd1,
        PLANE_BOTTOM = 3'd2,
        PLANE_TOP    = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5
    } plane_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } plane_t;

    typedef plane_t plane_arr_t [NUM_PLANES];

    typedef struct packed {
        logic signed [CRD_W-1:0] x0;
        logic signed [CRD_W-1:0] x1;
        logic signed [Y_W-1:0]   y0;
        logic signed [Y_W-1:0]   y1;
        logic signed [CRD_W-1:0] z0;
        logic signed [CRD_W-1:0] z1;
    } coord_t;

    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } stage_en_t;

endpackage

FILE: hdl/cbfc_apb_regs.sv
module cbfc_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cbfc_pkg::ADDR_W-1:0] paddr,
    input  logic [cbfc_pkg::DATA_W-1:0] pwdata,
    output logic [cbfc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output cbfc_pkg::plane_arr_t       planes
);
    import cbfc_pkg::*;

    plane_t            plane_reg [NUM_PLANES];
    logic [IDX_W-1:0]  idx;
    logic              idx_ok;

    assign idx    = paddr[ADDR_W-1:3];
    assign idx_ok = (idx <= PLANE_FAR);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && idx_ok) begin
            plane_reg[idx] <= plane_t'(pwdata);
        end
    end

    always_comb begin
        prdata = '0;
        if (idx_ok) begin
            prdata = DATA_W'(plane_reg[idx]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            planes[i] = plane_reg[i];
        end
    end

endmodule

FILE: hdl/cbfc_coord.sv
module cbfc_coord (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [cbfc_pkg::COL_W-1:0]    chunk_col_x,
    input  logic signed [cbfc_pkg::COL_W-1:0]    chunk_col_z,
    input  logic signed [cbfc_pkg::CAMXZ_W-1:0]  cam_x,
    input  logic signed [cbfc_pkg::CAMY_W-1:0]   cam_y,
    input  logic signed [cbfc_pkg::CAMXZ_W-1:0]  cam_z,
    output cbfc_pkg::coord_t                     coord
);
    import cbfc_pkg::*;

    coord_t                  coord_reg;
    coord_t                  coord_next;
    logic signed [CRD_W-1:0] x_base;
    logic signed [CRD_W-1:0] z_base;

    localparam logic signed [CRD_W-1:0] XS = CRD_W'(X_SPAN);
    localparam logic signed [CRD_W-1:0] ZS = CRD_W'(Z_SPAN);
    localparam logic signed [Y_W-1:0]   YS = Y_W'(Y_SPAN);

    always_comb begin
        x_base = CRD_W'(chunk_col_x) * XS - CRD_W'(cam_x);
        z_base = CRD_W'(chunk_col_z) * ZS - CRD_W'(cam_z);
        coord_next.x0 = x_base;
        coord_next.x1 = x_base + XS;
        coord_next.y0 = -Y_W'(cam_y);
        coord_next.y1 = YS - Y_W'(cam_y);
        coord_next.z0 = z_base;
        coord_next.z1 = z_base + ZS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

FILE: hdl/cbfc_plane_eval.sv
module cbfc_plane_eval (
    input  logic                 aclk,
    input  cbfc_pkg::stage_en_t  ctl,
    input  cbfc_pkg::plane_t     plane,
    input  cbfc_pkg::coord_t     coord,
    output logic                 culled
);
    import cbfc_pkg::*;

    // Only the corner farthest along the plane normal matters: if it is below,
    // all eight are.
    logic signed [CRD_W-1:0]    xs;
    logic signed [Y_W-1:0]      ys;
    logic signed [CRD_W-1:0]    zs;
    logic signed [PRD_XZ_W-1:0] px_reg, px_next;
    logic signed [PRD_Y_W-1:0]  py_reg, py_next;
    logic signed [PRD_XZ_W-1:0] pz_reg, pz_next;
    logic signed [ACC_W-1:0]    sum;
    logic                       culled_reg;

    always_comb begin
        xs = plane.a[COEF_W-1] ? coord.x0 : coord.x1;
        ys = plane.b[COEF_W-1] ? coord.y0 : coord.y1;
        zs = plane.c[COEF_W-1] ? coord.z0 : coord.z1;
        px_next = PRD_XZ_W'(plane.a) * PRD_XZ_W'(xs);
        py_next = PRD_Y_W'(plane.b) * PRD_Y_W'(ys);
        pz_next = PRD_XZ_W'(plane.c) * PRD_XZ_W'(zs);
    end

    always_comb begin
        sum = ACC_W'(px_reg) + ACC_W'(py_reg) + ACC_W'(pz_reg)
            + (ACC_W'(plane.d) <<< D_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_mul) begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
        if (ctl.en_sum) begin
            culled_reg <= sum[ACC_W-1];
        end
    end

    assign culled = culled_reg;

endmodule

FILE: hdl/chunk_box_frustum_cull.sv
// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      chunk_col_x, chunk_col_z, cam_x, cam_y, cam_z
// m_        out        m_valid / m_ready      visible
// apb       in         psel/penable/pwrite    paddr, pwdata, prdata (6 x 64-bit planes)
//
// One transaction per cycle sustained while m_ready stays high; four register stages (coordinates,
// per-plane multiplies, per-plane sum/sign, output register), each with its own valid; m_valid
// is the output-stage valid, and the result can be taken while it is high.
// Synchronous active-low reset clears stage valids and plane registers.
// A stall on m_ready holds each occupied stage; empty stages keep filling.
module chunk_box_frustum_cull (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cbfc_pkg::COL_W-1:0]    s_chunk_col_x,
    input  logic signed [cbfc_pkg::COL_W-1:0]    s_chunk_col_z,
    input  logic signed [cbfc_pkg::CAMXZ_W-1:0]  s_cam_x,
    input  logic signed [cbfc_pkg::CAMY_W-1:0]   s_cam_y,
    input  logic signed [cbfc_pkg::CAMXZ_W-1:0]  s_cam_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_visible,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbfc_pkg::ADDR_W-1:0]          paddr,
    input  logic [cbfc_pkg::DATA_W-1:0]          pwdata,
    output logic [cbfc_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import cbfc_pkg::*;

    plane_arr_t             planes;
    coord_t                 coord;
    stage_en_t              ctl;
    logic [NUM_PLANES-1:0]  culled;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic vis_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign ctl.en_mul = en2;
    assign ctl.en_sum = en3;

    assign s_ready   = en1;
    assign m_valid   = v4_reg;
    assign m_visible = vis_reg;

    cbfc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    cbfc_coord u_coord (
        .aclk        (aclk),
        .en          (en1),
        .chunk_col_x (s_chunk_col_x),
        .chunk_col_z (s_chunk_col_z),
        .cam_x       (s_cam_x),
        .cam_y       (s_cam_y),
        .cam_z       (s_cam_z),
        .coord       (coord)
    );

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        cbfc_plane_eval u_eval (
            .aclk   (aclk),
            .ctl    (ctl),
            .plane  (planes[p]),
            .coord  (coord),
            .culled (culled[p])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            vis_reg <= ~|culled;
        end
    end

endmodule

FILE: tb/cull_result_check.sv
module cull_result_check (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [cbfc_pkg::COL_W-1:0]    s_chunk_col_x,
    input  logic signed [cbfc_pkg::COL_W-1:0]    s_chunk_col_z,
    input  logic signed [cbfc_pkg::CAMXZ_W-1:0]  s_cam_x,
    input  logic signed [cbfc_pkg::CAMY_W-1:0]   s_cam_y,
    input  logic signed [cbfc_pkg::CAMXZ_W-1:0]  s_cam_z,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic                                 m_visible,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [cbfc_pkg::ADDR_W-1:0]          paddr,
    input  logic [cbfc_pkg::DATA_W-1:0]          pwdata,
    input  logic [cbfc_pkg::DATA_W-1:0]          prdata,
    output int                                   errors,
    output int                                   pending
);
    import cbfc_pkg::*;

    plane_t planes [NUM_PLANES];
    bit     visible_q [$];
    bit     want;

    function automatic longint plane_value(plane_t pl, longint x, longint y, longint z);
        longint a, b, c, d;
        a = $signed(pl.a);
        b = $signed(pl.b);
        c = $signed(pl.c);
        d = $signed(pl.d);
        // d is Q12.4, lift to Q.18 to line up with the products
        return a * x + b * y + c * z + d * (longint'(1) << D_SHIFT);
    endfunction

    function automatic bit box_visible(longint cx, longint cz, longint camx, longint camy,
                                       longint camz);
        longint xs [2];
        longint ys [2];
        longint zs [2];
        int     below;
        bit     vis;
        vis   = 1'b1;
        xs[0] = cx * X_SPAN - camx;
        xs[1] = xs[0] + X_SPAN;
        ys[0] = -camy;
        ys[1] = Y_SPAN - camy;
        zs[0] = cz * Z_SPAN - camz;
        zs[1] = zs[0] + Z_SPAN;
        for (int p = 0; p < NUM_PLANES; p++) begin
            below = 0;
            for (int k = 0; k < 8; k++) begin
                if (plane_value(planes[p], xs[k & 1], ys[(k >> 1) & 1], zs[(k >> 2) & 1]) < 0)
                    below++;
            end
            // a corner exactly on the plane keeps the box in
            if (below == 8)
                vis = 1'b0;
        end
        return vis;
    endfunction

    task automatic flag(input string msg);
        if (errors < 10)
            $display("%s", msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++)
                planes[i] = '0;
            visible_q.delete();
        end else begin
            // writes to unmapped indexes are dropped
            if (psel && penable && pready && paddr[ADDR_W-1:3] < NUM_PLANES) begin
                if (pwrite)
                    planes[paddr[ADDR_W-1:3]] = pwdata;
                else if (prdata !== planes[paddr[ADDR_W-1:3]])
                    flag($sformatf("plane readback idx %0d: expected %h got %h",
                                   paddr[ADDR_W-1:3], planes[paddr[ADDR_W-1:3]], prdata));
            end
            if (m_valid && m_ready) begin
                if (visible_q.size() == 0) begin
                    flag($sformatf("result transaction with nothing pending: visible %0b",
                                   m_visible));
                end else begin
                    want = visible_q[0];
                    visible_q.delete(0);
                    if (m_visible !== want)
                        flag($sformatf("visible mismatch: expected %0b got %0b",
                                       want, m_visible));
                end
            end
            if (s_valid && s_ready)
                visible_q.insert(visible_q.size(),
                                 box_visible($signed(s_chunk_col_x), $signed(s_chunk_col_z),
                                             $signed(s_cam_x), $signed(s_cam_y),
                                             $signed(s_cam_z)));
        end
        pending = visible_q.size();
    end

endmodule

FILE: tb/chunk_box_frustum_cull_test.sv
module chunk_box_frustum_cull_test;
    import cbfc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 108;

    localparam logic [IDX_W-1:0] NO_PLANE_LO = IDX_W'(6);
    localparam logic [IDX_W-1:0] NO_PLANE_HI = IDX_W'(7);

    localparam logic [COL_W-1:0]   COL_MIN = {1'b1, {(COL_W-1){1'b0}}};
    localparam logic [COL_W-1:0]   COL_MAX = ~COL_MIN;
    localparam logic [CAMXZ_W-1:0] CXZ_MIN = {1'b1, {(CAMXZ_W-1){1'b0}}};
    localparam logic [CAMXZ_W-1:0] CXZ_MAX = ~CXZ_MIN;
    localparam logic [CAMY_W-1:0]  CY_MIN  = {1'b1, {(CAMY_W-1){1'b0}}};
    localparam logic [CAMY_W-1:0]  CY_MAX  = ~CY_MIN;

    // unit normals along each axis, and a plane that every point is behind
    localparam logic [DATA_W-1:0] X_PLANE  = 64'h0000_0000_0000_4000;
    localparam logic [DATA_W-1:0] Y_PLANE  = 64'h0000_0000_4000_0000;
    localparam logic [DATA_W-1:0] Z_PLANE  = 64'h0000_4000_0000_0000;
    localparam logic [DATA_W-1:0] CULL_ALL = 64'hFFFF_0000_0000_0000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [COL_W-1:0]     s_chunk_col_x;
    logic [COL_W-1:0]     s_chunk_col_z;
    logic [CAMXZ_W-1:0]   s_cam_x;
    logic [CAMY_W-1:0]    s_cam_y;
    logic [CAMXZ_W-1:0]   s_cam_z;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    logic                 m_visible;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int errors;
    int pending;

    chunk_box_frustum_cull dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_chunk_col_x (s_chunk_col_x),
        .s_chunk_col_z (s_chunk_col_z),
        .s_cam_x       (s_cam_x),
        .s_cam_y       (s_cam_y),
        .s_cam_z       (s_cam_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_visible     (m_visible),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cull_result_check checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_chunk_col_x (s_chunk_col_x),
        .s_chunk_col_z (s_chunk_col_z),
        .s_cam_x       (s_cam_x),
        .s_cam_y       (s_cam_y),
        .s_cam_z       (s_cam_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_visible     (m_visible),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .errors        (errors),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL chunk_box_frustum_cull");
            $finish;
        end
    end

    task automatic send_chunk(input logic [COL_W-1:0] cx, input logic [COL_W-1:0] cz,
                              input logic [CAMXZ_W-1:0] camx, input logic [CAMY_W-1:0] camy,
                              input logic [CAMXZ_W-1:0] camz);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_chunk_col_x <= cx;
        s_chunk_col_z <= cz;
        s_cam_x       <= camx;
        s_cam_y       <= camy;
        s_cam_z       <= camz;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_chunk();
        logic signed [COL_W-1:0]   cx, cz;
        logic signed [CAMXZ_W-1:0] camx, camz;
        logic signed [CAMY_W-1:0]  camy;
        int                        off;
        if ($urandom_range(99) < 30) begin
            cx   = COL_W'($urandom);
            cz   = COL_W'($urandom);
            camx = CAMXZ_W'($urandom);
            camy = CAMY_W'($urandom);
            camz = CAMXZ_W'($urandom);
        end else begin
            // chunk a few columns from the camera, so planes straddle the box
            if ($urandom_range(1)) begin
                camx = CAMXZ_W'($urandom);
                camz = CAMXZ_W'($urandom);
            end else begin
                camx = CAMXZ_W'(int'($urandom_range(0, 16383)) - 8192);
                camz = CAMXZ_W'(int'($urandom_range(0, 16383)) - 8192);
            end
            camy = CAMY_W'(int'($urandom_range(0, 8191)) - 2048);
            off  = int'($urandom_range(0, 8)) - 4;
            cx   = COL_W'((camx >>> 8) + off);
            off  = int'($urandom_range(0, 8)) - 4;
            cz   = COL_W'((camz >>> 8) + off);
        end
        send_chunk(cx, cz, camx, camy, camz);
    endtask

    function automatic logic [DATA_W-1:0] random_plane();
        logic [COEF_W-1:0] a, b, c, d;
        if ($urandom_range(99) < 40)
            return '0;
        a = COEF_W'($urandom);
        b = COEF_W'($urandom);
        c = COEF_W'($urandom);
        if ($urandom_range(1))
            d = COEF_W'(int'($urandom_range(0, 255)) - 128);
        else
            d = COEF_W'($urandom);
        return {d, c, b, a};
    endfunction

    // let the pipe empty before touching the planes
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic plane_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic plane_read(input logic [IDX_W-1:0] idx);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_all_planes(input logic [DATA_W-1:0] val);
        for (int i = 0; i < NUM_PLANES; i++)
            plane_write(IDX_W'(i), val);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_chunk_col_x = '0;
        s_chunk_col_z = '0;
        s_cam_x       = '0;
        s_cam_y       = '0;
        s_cam_z       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // planes still at reset: nothing can be culled
        send_chunk(COL_MIN, COL_MIN, CXZ_MIN, CY_MIN, CXZ_MIN);
        send_chunk(COL_MAX, COL_MAX, CXZ_MAX, CY_MAX, CXZ_MAX);
        send_chunk(COL_MIN, COL_MAX, CXZ_MAX, CY_MIN, CXZ_MIN);

        // far corner landing exactly on a plane stays visible, one step past it is culled
        plane_write(PLANE_LEFT, X_PLANE);
        send_chunk('0, '0, CAMXZ_W'(256), '0, '0);
        send_chunk('0, '0, CAMXZ_W'(257), '0, '0);
        send_chunk('0, '0, CAMXZ_W'(255), '0, '0);
        plane_write(PLANE_BOTTOM, Y_PLANE);
        send_chunk('0, '0, '0, CAMY_W'(4096), '0);
        send_chunk('0, '0, '0, CAMY_W'(4097), '0);
        plane_write(PLANE_NEAR, Z_PLANE);
        send_chunk('0, '0, '0, '0, CAMXZ_W'(256));
        send_chunk('0, '0, '0, '0, CAMXZ_W'(257));

        // extreme coefficients against extreme coordinates
        set_all_planes(64'h8000_8000_8000_8000);
        send_chunk(COL_MAX, COL_MAX, CXZ_MIN, CY_MIN, CXZ_MIN);
        send_chunk(COL_MIN, COL_MIN, CXZ_MAX, CY_MAX, CXZ_MAX);
        send_chunk(COL_MAX, COL_MIN, CXZ_MIN, CY_MAX, CXZ_MAX);
        set_all_planes(64'h7FFF_7FFF_7FFF_7FFF);
        send_chunk(COL_MIN, COL_MIN, CXZ_MAX, CY_MAX, CXZ_MAX);

        // each plane alone can cull
        set_all_planes('0);
        for (int i = 0; i < NUM_PLANES; i++) begin
            plane_write(IDX_W'(i), CULL_ALL);
            send_chunk('0, '0, '0, '0, '0);
            plane_write(IDX_W'(i), '0);
        end

        // unmapped indexes must not land in any plane
        plane_write(NO_PLANE_LO, CULL_ALL);
        plane_write(NO_PLANE_HI, CULL_ALL);
        send_chunk('0, '0, '0, '0, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            case (ph)
                0: set_all_planes('1);
                1: set_all_planes(64'h7FFF_7FFF_7FFF_7FFF);
                2: set_all_planes(64'h8000_8000_8000_8000);
                3: set_all_planes('0);
                default: begin
                    for (int i = 0; i < NUM_PLANES; i++)
                        plane_write(IDX_W'(i), random_plane());
                end
            endcase
            for (int i = 0; i < NUM_PLANES; i++)
                plane_read(IDX_W'(i));
            repeat (PHASE_ITEMS) random_chunk();
        end

        drain();
        if (errors == 0)
            $display("PASS chunk_box_frustum_cull");
        else
            $display("FAIL chunk_box_frustum_cull");
        $finish;
    end

endmodule
